FILE: hw/rtl/sht_pkg.sv
// Package with the shared types, constants and score helpers of the search hash table engine.
package sht_pkg;

    localparam int BOUND_ENTRIES = 4096;
    localparam int REPEAT_ENTRIES = 1024;
    localparam int BND_AW = $clog2(BOUND_ENTRIES);
    localparam int REP_AW = $clog2(REPEAT_ENTRIES);
    localparam int CNT_W = (BND_AW > REP_AW) ? BND_AW : REP_AW;

    localparam logic [CNT_W-1:0] BND_LAST = CNT_W'(BOUND_ENTRIES - 1);
    localparam logic [CNT_W-1:0] REP_LAST = CNT_W'(REPEAT_ENTRIES - 1);
    localparam logic [CNT_W-1:0] ALL_LAST = (BND_LAST > REP_LAST) ? BND_LAST : REP_LAST;

    localparam logic [14:0] MATE_RESET = 15'd31000;
    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [7:0] DRAW_COUNT = 8'd3;
    localparam logic [7:0] REPEAT_LIMIT = 8'd1;

    typedef enum logic [2:0] {
        ACT_DRAW      = 3'd0,
        ACT_PUSH      = 3'd1,
        ACT_POP       = 3'd2,
        ACT_REP_CLEAR = 3'd3,
        ACT_LOOKUP    = 3'd4,
        ACT_RECORD    = 3'd5,
        ACT_MOVE      = 3'd6,
        ACT_BND_CLEAR = 3'd7
    } action_t;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_CLEAR = 2'd2
    } state_t;

    typedef struct packed {
        action_t            act;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         ply;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [15:0]        move;
    } op_t;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  count;
    } rep_entry_t;

    typedef struct packed {
        logic [63:0]        key;
        logic [7:0]         depth;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [15:0]        move;
    } bnd_entry_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] score;
    } lookup_res_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sht_lookup.sv
// Score evaluation of a bound table lookup, with mate distance adjustment toward the node.
module sht_lookup (
    input  logic [14:0]          mate_thr,
    input  sht_pkg::op_t         op,
    input  sht_pkg::bnd_entry_t  entry,
    input  logic                 rep_block,
    output sht_pkg::lookup_res_t res
);
    import sht_pkg::*;

    logic signed [17:0] thr;
    logic signed [17:0] ply_s;
    logic signed [17:0] e0;
    logic signed [17:0] e1;
    logic signed [17:0] e2;
    logic signed [15:0] e;
    logic               usable;

    always_comb begin
        thr = signed'({3'b000, mate_thr});
        ply_s = signed'({10'd0, op.ply});
        e0 = 18'(entry.score);
        e1 = (e0 >= thr) ? (e0 - ply_s) : e0;
        e2 = (e1 <= -thr) ? (e1 + ply_s) : e1;
        e = sat16(e2);
        usable = !rep_block && (entry.key == op.key) && (entry.depth >= op.depth);
        res = '0;
        if (usable) begin
            if (entry.kind == KIND_EXACT) begin
                res.valid = 1'b1;
                res.score = e;
            end else if ((entry.kind == KIND_UPPER) && (e <= op.alpha)) begin
                res.valid = 1'b1;
                res.score = op.alpha;
            end else if ((entry.kind == KIND_LOWER) && (e >= op.beta)) begin
                res.valid = 1'b1;
                res.score = op.beta;
            end
        end
    end

endmodule

FILE: hw/rtl/search_hash_table_engine.sv
// Top level of the search hash table engine: repetition and bound tables in on-chip memory.
//
//   channel   ports                                        transfer
//   command   start, busy, action .. move_in               start high and busy low
//   result    done, score_valid .. move_out                done high, one cycle
//   config    cfg_we, cfg_wdata                            cfg_we high
//
// A table action reads its slot in the accept cycle and writes it back in the next cycle,
// so a new command can be taken every cycle while busy is low; the result is registered
// from the execute state. A clear walks its table one entry per cycle with busy high;
// its result is shown once busy falls. After reset both tables are cleared in one pass
// with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
module search_hash_table_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic [2:0]  action,
    input  logic [63:0] position_key,
    input  logic [7:0]  search_depth,
    input  logic [15:0] alpha_bound,
    input  logic [15:0] beta_bound,
    input  logic [7:0]  ply_distance,
    input  logic [1:0]  bound_kind,
    input  logic [15:0] score_in,
    input  logic [15:0] move_in,
    output logic        score_valid,
    output logic [15:0] score_out,
    output logic        is_draw,
    output logic        move_valid,
    output logic [15:0] move_out
);
    import sht_pkg::*;

    rep_entry_t rep_mem [REPEAT_ENTRIES];
    bnd_entry_t bnd_mem [BOUND_ENTRIES];

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic        clr_rep_reg, clr_rep_next;
    logic        clr_bnd_reg, clr_bnd_next;
    logic        clr_report_reg, clr_report_next;
    logic        done_reg, done_next;
    logic [14:0] mate_thr_reg;
    op_t         op_reg;
    op_t         op_in;
    logic        accept;

    rep_entry_t  rep_q_reg;
    bnd_entry_t  bnd_q_reg;
    rep_entry_t  rep_fwd_reg;
    bnd_entry_t  bnd_fwd_reg;
    logic        rep_fwd_valid_reg, rep_fwd_valid_next;
    logic        bnd_fwd_valid_reg, bnd_fwd_valid_next;

    rep_entry_t  rep_cur;
    bnd_entry_t  bnd_cur;
    logic        rep_match;
    logic        bnd_match;
    logic        rep_block;
    logic        ex_rep_we;
    logic        ex_bnd_we;
    rep_entry_t  ex_rep_data;
    bnd_entry_t  ex_bnd_data;
    logic        ex_draw;
    logic        ex_move_valid;
    logic [15:0] ex_move;
    lookup_res_t look_res;

    logic               rec_win;
    logic signed [17:0] rec_thr;
    logic signed [17:0] rec_ply;
    logic signed [17:0] rec_e1;
    logic signed [17:0] rec_e2;

    logic              rep_we;
    logic [REP_AW-1:0] rep_waddr;
    rep_entry_t        rep_wdata;
    logic              bnd_we;
    logic [BND_AW-1:0] bnd_waddr;
    bnd_entry_t        bnd_wdata;

    logic [CNT_W-1:0] clr_last;

    logic        score_valid_reg, score_valid_next;
    logic [15:0] score_out_reg, score_out_next;
    logic        is_draw_reg, is_draw_next;
    logic        move_valid_reg, move_valid_next;
    logic [15:0] move_out_reg, move_out_next;

    assign busy = (state_reg == ST_CLEAR);
    assign accept = start && !busy;
    assign done = done_reg;
    assign score_valid = score_valid_reg;
    assign score_out = score_out_reg;
    assign is_draw = is_draw_reg;
    assign move_valid = move_valid_reg;
    assign move_out = move_out_reg;

    always_comb begin
        op_in.act = action_t'(action);
        op_in.key = position_key;
        op_in.depth = search_depth;
        op_in.alpha = signed'(alpha_bound);
        op_in.beta = signed'(beta_bound);
        op_in.ply = ply_distance;
        op_in.kind = bound_kind;
        op_in.score = signed'(score_in);
        op_in.move = move_in;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mate_thr_reg <= MATE_RESET;
        end else if (cfg_we) begin
            mate_thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            op_reg <= op_in;
        end
    end

    // The slot is read in the accept cycle; a write-back at the same edge is forwarded.
    always_ff @(posedge clk) begin
        if (rep_we) begin
            rep_mem[rep_waddr] <= rep_wdata;
        end
        if (accept) begin
            rep_q_reg <= rep_mem[position_key[REP_AW-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (bnd_we) begin
            bnd_mem[bnd_waddr] <= bnd_wdata;
        end
        if (accept) begin
            bnd_q_reg <= bnd_mem[position_key[BND_AW-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        rep_fwd_reg <= rep_wdata;
        bnd_fwd_reg <= bnd_wdata;
    end

    always_comb begin
        rep_fwd_valid_next = accept && (state_reg == ST_EXEC) && ex_rep_we
            && (position_key[REP_AW-1:0] == op_reg.key[REP_AW-1:0]);
        bnd_fwd_valid_next = accept && (state_reg == ST_EXEC) && ex_bnd_we
            && (position_key[BND_AW-1:0] == op_reg.key[BND_AW-1:0]);
    end

    always_comb begin
        rep_cur = rep_fwd_valid_reg ? rep_fwd_reg : rep_q_reg;
        bnd_cur = bnd_fwd_valid_reg ? bnd_fwd_reg : bnd_q_reg;
        rep_match = (rep_cur.key == op_reg.key);
        bnd_match = (bnd_cur.key == op_reg.key);
        rep_block = rep_match && (rep_cur.count > REPEAT_LIMIT);

        rec_thr = signed'({3'b000, mate_thr_reg});
        rec_ply = signed'({10'd0, op_reg.ply});
        rec_win = (18'(op_reg.score) >= rec_thr);
        rec_e1 = rec_win ? (18'(op_reg.score) + rec_ply) : 18'(op_reg.score);
        rec_e2 = (rec_e1 <= -rec_thr) ? (rec_e1 - rec_ply) : rec_e1;

        ex_rep_we = 1'b0;
        ex_rep_data = rep_cur;
        ex_bnd_we = 1'b0;
        ex_bnd_data = bnd_cur;
        ex_draw = 1'b0;
        ex_move_valid = 1'b0;
        ex_move = '0;

        case (op_reg.act)
            ACT_DRAW: begin
                ex_draw = rep_match && (rep_cur.count >= DRAW_COUNT);
            end
            ACT_PUSH: begin
                if (rep_match) begin
                    ex_rep_we = 1'b1;
                    if (rep_cur.count != COUNT_MAX) begin
                        ex_rep_data.count = rep_cur.count + 8'd1;
                    end
                end else if (rep_cur.count == 8'd0) begin
                    ex_rep_we = 1'b1;
                    ex_rep_data.key = op_reg.key;
                    ex_rep_data.count = 8'd1;
                end
            end
            ACT_POP: begin
                if (rep_match && (rep_cur.count != 8'd0)) begin
                    ex_rep_we = 1'b1;
                    ex_rep_data.count = rep_cur.count - 8'd1;
                end
            end
            ACT_RECORD: begin
                ex_bnd_we = 1'b1;
                ex_bnd_data.key = op_reg.key;
                ex_bnd_data.depth = op_reg.depth;
                ex_bnd_data.kind = op_reg.kind;
                ex_bnd_data.score = sat16(rec_e2);
                ex_bnd_data.move = op_reg.move;
            end
            ACT_MOVE: begin
                if (bnd_match) begin
                    ex_move_valid = 1'b1;
                    ex_move = bnd_cur.move;
                end
            end
            default: begin
            end
        endcase
    end

    sht_lookup u_lookup (
        .mate_thr  (mate_thr_reg),
        .op        (op_reg),
        .entry     (bnd_cur),
        .rep_block (rep_block),
        .res       (look_res)
    );

    always_comb begin
        rep_we = 1'b0;
        rep_waddr = op_reg.key[REP_AW-1:0];
        rep_wdata = ex_rep_data;
        bnd_we = 1'b0;
        bnd_waddr = op_reg.key[BND_AW-1:0];
        bnd_wdata = ex_bnd_data;
        if (state_reg == ST_CLEAR) begin
            rep_we = clr_rep_reg;
            rep_waddr = cnt_reg[REP_AW-1:0];
            rep_wdata = '0;
            bnd_we = clr_bnd_reg;
            bnd_waddr = cnt_reg[BND_AW-1:0];
            bnd_wdata = '0;
        end else if (state_reg == ST_EXEC) begin
            rep_we = ex_rep_we;
            bnd_we = ex_bnd_we;
        end
    end

    always_comb begin
        if (clr_rep_reg && clr_bnd_reg) begin
            clr_last = ALL_LAST;
        end else if (clr_bnd_reg) begin
            clr_last = BND_LAST;
        end else begin
            clr_last = REP_LAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            clr_rep_reg <= 1'b1;
            clr_bnd_reg <= 1'b1;
            clr_report_reg <= 1'b0;
            done_reg <= 1'b0;
            rep_fwd_valid_reg <= 1'b0;
            bnd_fwd_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            clr_rep_reg <= clr_rep_next;
            clr_bnd_reg <= clr_bnd_next;
            clr_report_reg <= clr_report_next;
            done_reg <= done_next;
            rep_fwd_valid_reg <= rep_fwd_valid_next;
            bnd_fwd_valid_reg <= bnd_fwd_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        score_valid_reg <= score_valid_next;
        score_out_reg <= score_out_next;
        is_draw_reg <= is_draw_next;
        move_valid_reg <= move_valid_next;
        move_out_reg <= move_out_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        clr_rep_next = clr_rep_reg;
        clr_bnd_next = clr_bnd_reg;
        clr_report_next = clr_report_reg;
        done_next = 1'b0;
        score_valid_next = 1'b0;
        score_out_next = '0;
        is_draw_next = 1'b0;
        move_valid_next = 1'b0;
        move_out_next = '0;

        case (state_reg)
            ST_IDLE, ST_EXEC: begin
                if (state_reg == ST_EXEC) begin
                    done_next = 1'b1;
                    if (op_reg.act == ACT_LOOKUP) begin
                        score_valid_next = look_res.valid;
                        score_out_next = look_res.score;
                    end
                    is_draw_next = ex_draw;
                    move_valid_next = ex_move_valid;
                    move_out_next = ex_move;
                    state_next = ST_IDLE;
                end
                if (accept) begin
                    if (op_in.act == ACT_REP_CLEAR || op_in.act == ACT_BND_CLEAR) begin
                        state_next = ST_CLEAR;
                        cnt_next = '0;
                        clr_rep_next = (op_in.act == ACT_REP_CLEAR);
                        clr_bnd_next = (op_in.act == ACT_BND_CLEAR);
                        clr_report_next = 1'b1;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == clr_last) begin
                    state_next = ST_IDLE;
                    done_next = clr_report_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> done_reg)
        else $error("table action finished without a result");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({score_valid_reg, is_draw_reg, move_valid_reg}))
        else $error("more than one result flag set");

    a_fwd_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rep_fwd_valid_reg || bnd_fwd_valid_reg) |-> (state_reg != ST_IDLE))
        else $error("forwarding active while idle");

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (cnt_reg <= clr_last))
        else $error("clear walk ran past the table");

    a_no_done_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLEAR) && $past(state_reg == ST_CLEAR)) |-> !done_reg)
        else $error("result shown in the middle of a clear");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the search hash table engine: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import sht_pkg::*;

    typedef struct packed {
        logic               sv;
        logic signed [15:0] so;
        logic               dr;
        logic               mv;
        logic [15:0]        mo;
    } outcome_t;

    typedef struct {
        op_t      cmd;
        bit       typed;
        outcome_t want;
    } row_t;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int RANDOM_ITEMS = 90;
    localparam outcome_t OUT_NONE = '0;
    localparam outcome_t OUT_SCORE0 = '{sv: 1'b1, so: 16'sd0, dr: 1'b0, mv: 1'b0, mo: 16'd0};
    localparam outcome_t OUT_DRAW = '{sv: 1'b0, so: 16'sd0, dr: 1'b1, mv: 1'b0, mo: 16'd0};
    localparam outcome_t OUT_MOVE0 = '{sv: 1'b0, so: 16'sd0, dr: 1'b0, mv: 1'b1, mo: 16'd0};

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    logic [2:0]  action;
    logic [63:0] position_key;
    logic [7:0]  search_depth;
    logic [15:0] alpha_bound;
    logic [15:0] beta_bound;
    logic [7:0]  ply_distance;
    logic [1:0]  bound_kind;
    logic [15:0] score_in;
    logic [15:0] move_in;
    logic        score_valid;
    logic [15:0] score_out;
    logic        is_draw;
    logic        move_valid;
    logic [15:0] move_out;

    rep_entry_t  repeat_shadow [REPEAT_ENTRIES];
    bnd_entry_t  bound_shadow [BOUND_ENTRIES];
    logic [14:0] mate_limit;
    outcome_t    pending_results [$];
    row_t        directed_rows [$];
    logic [63:0] key_pool [16];

    int errors;
    int cycles;
    int transfers;
    int results_checked;
    int draws_seen;
    int scores_seen;
    int moves_seen;
    int burst_left;

    search_hash_table_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .position_key (position_key),
        .search_depth (search_depth),
        .alpha_bound  (alpha_bound),
        .beta_bound   (beta_bound),
        .ply_distance (ply_distance),
        .bound_kind   (bound_kind),
        .score_in     (score_in),
        .move_in      (move_in),
        .score_valid  (score_valid),
        .score_out    (score_out),
        .is_draw      (is_draw),
        .move_valid   (move_valid),
        .move_out     (move_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [15:0] clamp16(input int v);
        logic signed [15:0] r;
        if (v > 32767)
            r = 16'sh7fff;
        else if (v < -32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic outcome_t table_apply(input op_t c);
        outcome_t   o;
        rep_entry_t r;
        bnd_entry_t b;
        int         e;
        int         thr;
        int         ply;
        int         lo;
        int         hi;
        o = '0;
        r = repeat_shadow[c.key[REP_AW-1:0]];
        b = bound_shadow[c.key[BND_AW-1:0]];
        thr = int'(mate_limit);
        ply = int'(c.ply);
        lo = $signed(c.alpha);
        hi = $signed(c.beta);
        case (c.act)
            ACT_DRAW:
                o.dr = (r.key == c.key) && (r.count >= DRAW_COUNT);
            ACT_PUSH:
            begin
                if (r.key == c.key)
                begin
                    if (r.count < COUNT_MAX)
                        r.count = r.count + 8'd1;
                end
                else if (r.count == 8'd0)
                begin
                    r.key = c.key;
                    r.count = 8'd1;
                end
                repeat_shadow[c.key[REP_AW-1:0]] = r;
            end
            ACT_POP:
            begin
                if (r.key == c.key && r.count > 8'd0)
                    r.count = r.count - 8'd1;
                repeat_shadow[c.key[REP_AW-1:0]] = r;
            end
            ACT_REP_CLEAR:
                foreach (repeat_shadow[i])
                    repeat_shadow[i] = '0;
            ACT_LOOKUP:
            begin
                if (!(r.key == c.key && r.count > REPEAT_LIMIT) && b.key == c.key
                    && b.depth >= c.depth)
                begin
                    e = $signed(b.score);
                    if (e >= thr)
                        e = e - ply;
                    if (e <= -thr)
                        e = e + ply;
                    e = clamp16(e);
                    if (b.kind == KIND_EXACT)
                    begin
                        o.sv = 1'b1;
                        o.so = e[15:0];
                    end
                    else if (b.kind == KIND_UPPER && e <= lo)
                    begin
                        o.sv = 1'b1;
                        o.so = c.alpha;
                    end
                    else if (b.kind == KIND_LOWER && e >= hi)
                    begin
                        o.sv = 1'b1;
                        o.so = c.beta;
                    end
                end
            end
            ACT_RECORD:
            begin
                e = $signed(c.score);
                if (e >= thr)
                    e = e + ply;
                if (e <= -thr)
                    e = e - ply;
                b.key = c.key;
                b.depth = c.depth;
                b.kind = c.kind;
                b.score = clamp16(e);
                b.move = c.move;
                bound_shadow[c.key[BND_AW-1:0]] = b;
            end
            ACT_MOVE:
            begin
                if (b.key == c.key)
                begin
                    o.mv = 1'b1;
                    o.mo = b.move;
                end
            end
            default:
                foreach (bound_shadow[i])
                    bound_shadow[i] = '0;
        endcase
        return o;
    endfunction

    function automatic op_t mk(input action_t a, input logic [63:0] k, input int d,
                               input int al, input int be, input int p, input int kd,
                               input int sc, input int mv);
        op_t c;
        c.act = a;
        c.key = k;
        c.depth = d[7:0];
        c.alpha = al[15:0];
        c.beta = be[15:0];
        c.ply = p[7:0];
        c.kind = kd[1:0];
        c.score = sc[15:0];
        c.move = mv[15:0];
        return c;
    endfunction

    function automatic logic signed [15:0] pick_score();
        int thr;
        int s;
        thr = int'(mate_limit);
        case ($urandom_range(0, 3))
            0: s = $signed(16'($urandom));
            1: s = thr + $urandom_range(0, 300) - 150;
            2: s = -thr - $urandom_range(0, 300) + 150;
            default: s = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        return clamp16(s);
    endfunction

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        if ($urandom_range(0, 9) < 8)
            k = key_pool[$urandom_range(0, 15)];
        else
            k = {$urandom, $urandom};
        return k;
    endfunction

    function automatic op_t random_op(input logic [63:0] k);
        op_t c;
        int  w;
        w = $urandom_range(0, 199);
        if (w < 40)
            c.act = ACT_PUSH;
        else if (w < 64)
            c.act = ACT_POP;
        else if (w < 88)
            c.act = ACT_DRAW;
        else if (w < 128)
            c.act = ACT_LOOKUP;
        else if (w < 164)
            c.act = ACT_RECORD;
        else if (w < 196)
            c.act = ACT_MOVE;
        else if (w < 198)
            c.act = ACT_REP_CLEAR;
        else
            c.act = ACT_BND_CLEAR;
        c.key = k;
        c.depth = 8'($urandom);
        c.alpha = 16'($urandom);
        c.beta = 16'($urandom);
        c.ply = 8'($urandom);
        c.kind = 2'($urandom_range(0, 3));
        c.score = pick_score();
        c.move = 16'($urandom);
        return c;
    endfunction

    task automatic send(input op_t c, input bit typed, input outcome_t want);
        outcome_t predicted;
        start <= 1'b1;
        action <= c.act;
        position_key <= c.key;
        search_depth <= c.depth;
        alpha_bound <= c.alpha;
        beta_bound <= c.beta;
        ply_distance <= c.ply;
        bound_kind <= c.kind;
        score_in <= c.score;
        move_in <= c.move;
        do
            @(posedge clk);
        while (busy);
        predicted = table_apply(c);
        pending_results.push_back(typed ? want : predicted);
        transfers++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic settle_and_configure(input logic [14:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mate_limit = v;
    endtask

    task automatic random_traffic(input int n);
        op_t         c;
        op_t         q;
        logic [63:0] k;
        int          sc;
        int          i;
        i = 0;
        while (i < n)
        begin
            k = pick_key();
            if ($urandom_range(0, 9) < 6)
            begin
                c = random_op(k);
                c.act = ACT_RECORD;
                send(c, 1'b0, OUT_NONE);
                i++;
                sc = c.score;
                repeat ($urandom_range(1, 4))
                begin
                    q = random_op(k);
                    case ($urandom_range(0, 5))
                        0, 1: q.act = ACT_LOOKUP;
                        2: q.act = ACT_MOVE;
                        3: q.act = ACT_PUSH;
                        4: q.act = ACT_DRAW;
                        default: q.act = ACT_POP;
                    endcase
                    if ($urandom_range(0, 1))
                    begin
                        q.alpha = clamp16(sc + $urandom_range(0, 600) - 300);
                        q.beta = clamp16(sc + $urandom_range(0, 600) - 300);
                        q.ply = 8'($urandom_range(0, 20));
                    end
                    send(q, 1'b0, OUT_NONE);
                    i++;
                end
            end
            else
            begin
                send(random_op(k), 1'b0, OUT_NONE);
                i++;
            end
        end
    endtask

    task automatic plan(input op_t c, input bit typed, input outcome_t want);
        row_t r;
        r.cmd = c;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done)
        begin
            got = '{sv: score_valid, so: score_out, dr: is_draw, mv: move_valid,
                    mo: move_out};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: sv=%0d so=%0d dr=%0d mv=%0d mo=%0d",
                         $time, got.sv, got.so, got.dr, got.mv, got.mo);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                draws_seen += got.dr;
                scores_seen += got.sv;
                moves_seen += got.mv;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch expected sv=%0d so=%0d dr=%0d mv=%0d mo=%0d",
                             $time, want.sv, want.so, want.dr, want.mv, want.mo);
                    $display("%0t:          actual   sv=%0d so=%0d dr=%0d mv=%0d mo=%0d",
                             $time, got.sv, got.so, got.dr, got.mv, got.mo);
                end
            end
        end
    end

    initial
    begin
        logic [63:0] k0;
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kf;
        logic [63:0] hk;
        rst_n <= 1'b0;
        start <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        action <= ACT_DRAW;
        position_key <= '0;
        search_depth <= '0;
        alpha_bound <= '0;
        beta_bound <= '0;
        ply_distance <= '0;
        bound_kind <= KIND_EXACT;
        score_in <= '0;
        move_in <= '0;
        errors = 0;
        cycles = 0;
        transfers = 0;
        results_checked = 0;
        draws_seen = 0;
        scores_seen = 0;
        moves_seen = 0;
        burst_left = 0;
        mate_limit = MATE_RESET;
        foreach (repeat_shadow[i])
            repeat_shadow[i] = '0;
        foreach (bound_shadow[i])
            bound_shadow[i] = '0;

        key_pool[0] = '0;
        for (int i = 1; i < 16; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 8; i < 12; i++)
            key_pool[i][BND_AW-1:0] = key_pool[i-8][BND_AW-1:0];
        for (int i = 12; i < 16; i++)
            key_pool[i][REP_AW-1:0] = key_pool[i-8][REP_AW-1:0];

        k0 = 64'h0;
        ka = 64'h0000_0000_0000_0400;
        kb = 64'h8000_0000_0000_0000;
        kf = '1;

        // Empty slots match key 0; counting, repeats and draws on one slot.
        plan(mk(ACT_DRAW, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_PUSH, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_LOOKUP, k0, 0, -32768, 32767, 0, 0, 0, 0), 1'b1, OUT_SCORE0);
        plan(mk(ACT_MOVE, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_MOVE0);
        plan(mk(ACT_PUSH, kb, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_PUSH, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_LOOKUP, k0, 0, -32768, 32767, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_PUSH, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_DRAW, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_DRAW);
        plan(mk(ACT_DRAW, kb, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        for (int i = 0; i < 4; i++)
            plan(mk(ACT_POP, k0, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_PUSH, kb, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        // Mate scores at the field extremes, every bound kind, key mismatch on a move.
        plan(mk(ACT_RECORD, kf, 255, 0, 0, 255, 0, 32767, 65535), 1'b0, OUT_NONE);
        plan(mk(ACT_LOOKUP, kf, 255, -32768, 32767, 0, 0, 0, 0), 1'b0, OUT_NONE);
        plan(mk(ACT_MOVE, kf, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        plan(mk(ACT_RECORD, kf, 255, 0, 0, 255, 2, -32768, 0), 1'b0, OUT_NONE);
        plan(mk(ACT_LOOKUP, kf, 0, 0, -32768, 255, 0, 0, 0), 1'b0, OUT_NONE);
        plan(mk(ACT_RECORD, k0, 3, 0, 0, 1, 1, 31000, 4660), 1'b0, OUT_NONE);
        plan(mk(ACT_LOOKUP, k0, 3, 32767, 0, 1, 0, 0, 0), 1'b0, OUT_NONE);
        plan(mk(ACT_LOOKUP, k0, 4, 32767, 0, 1, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_RECORD, ka, 10, 0, 0, 0, 3, 5, 7), 1'b0, OUT_NONE);
        plan(mk(ACT_LOOKUP, ka, 0, 32767, -32768, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_MOVE, kb, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_REP_CLEAR, kf, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);
        plan(mk(ACT_BND_CLEAR, kf, 0, 0, 0, 0, 0, 0, 0), 1'b1, OUT_NONE);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        settle_and_configure(15'd0);
        random_traffic(RANDOM_ITEMS);

        // Saturate one repetition count, then step it down by one pop, with a draw check before and after.
        settle_and_configure(15'd32767);
        hk = pick_key();
        send(mk(ACT_REP_CLEAR, hk, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        repeat (257)
            send(mk(ACT_PUSH, hk, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        send(mk(ACT_DRAW, hk, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        send(mk(ACT_POP, hk, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        send(mk(ACT_DRAW, hk, 0, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
        random_traffic(RANDOM_ITEMS);

        settle_and_configure(15'($urandom_range(1, 32766)));
        random_traffic(RANDOM_ITEMS);

        settle_and_configure(MATE_RESET);
        random_traffic(RANDOM_ITEMS);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d command transfers over four mate thresholds; %0d results checked.",
                 transfers, results_checked);
        $display("Results carried %0d scores, %0d draws and %0d moves; %0d errors.",
                 scores_seen, draws_seen, moves_seen, errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
